// ----- rtl/mts_pkg.sv -----
// Package with the shared types and codes of the minimum-tracking stack.
package mts_pkg;

    localparam int DATA_W  = 32;
    localparam int DEPTH_W = 9;

    typedef logic        [1:0]         t_op;
    typedef logic        [1:0]         t_status;
    typedef logic signed [DATA_W-1:0]  t_data;
    typedef logic        [DEPTH_W-1:0] t_depth;

    localparam t_op OP_PUSH = 2'd0;
    localparam t_op OP_POP  = 2'd1;
    localparam t_op OP_READ = 2'd2;

    localparam t_status ST_DONE  = 2'd0;
    localparam t_status ST_FULL  = 2'd1;
    localparam t_status ST_EMPTY = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD_TOP,
        S_RD_MIN,
        S_HOLD
    } t_state;

    typedef struct packed {
        t_data   top_value;
        logic    top_valid;
        t_data   min_value;
        logic    min_valid;
        t_depth  depth;
        t_status status;
    } t_result;

endpackage

// ----- rtl/mts_in_if.sv -----
// Interface for the operation channel of the minimum-tracking stack.
interface mts_in_if;
    logic                      valid;
    logic                      ready;
    mts_pkg::t_op              operation;
    mts_pkg::t_data            push_value;

    modport source (output valid, output operation, output push_value, input ready);
    modport sink   (input valid, input operation, input push_value, output ready);
endinterface

// ----- rtl/mts_out_if.sv -----
// Interface for the result channel of the minimum-tracking stack.
interface mts_out_if;
    logic                      valid;
    logic                      ready;
    mts_pkg::t_data            top_value;
    logic                      top_valid;
    mts_pkg::t_data            min_value;
    logic                      min_valid;
    mts_pkg::t_depth           depth;
    mts_pkg::t_status          status;

    modport source (output valid, output top_value, output top_valid, output min_value,
                    output min_valid, output depth, output status, input ready);
    modport sink   (input valid, input top_value, input top_valid, input min_value,
                    input min_valid, input depth, input status, output ready);
endinterface

// ----- rtl/mts_ram.sv -----
// Simple dual-port memory with one write port and one registered read port.
module mts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/min_tracking_stack_unit.sv -----
// Top level of the bounded stack that reports its current minimum.
//
// Operations arrive on i_in: push, pop or read (code 3 acts as a read). Each
// transaction yields exactly one result on o_out with the top value (the
// popped value for a pop), the minimum, the depth and a status code.
// Values live in one memory and the indices of successive minima in a second
// one; the top value, the minimum and its index are held in registers.
// A push, a read, a rejected operation or a pop that empties the stack
// completes in the cycle it is accepted; its result is registered in the
// output register that drives o_out.
// A pop that leaves at least one entry refills the cached top from memory
// (state S_RD_TOP), reading the index of the new minimum alongside, and,
// when the minimum was popped, then fetches that minimum's value (state
// S_RD_MIN). The block takes one operation every cycle for pushes, reads
// and pops that empty the stack while no result is parked; a pop that leaves
// entries behind holds off the next operation until its result is made.
// A new operation is accepted while an earlier result still waits on o_out;
// if a further result is ready before that one is taken, it is parked and
// the input stalls until the output register frees.
// Reset empties the stack; memory contents need no clearing.
module min_tracking_stack_unit #(
    parameter int STACK_DEPTH = 256
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    mts_in_if.sink           i_in,
    mts_out_if.source        o_out
);
    import mts_pkg::*;

    localparam int IW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    t_state              r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_min_count, n_min_count;
    t_data               r_top, n_top;
    t_data               r_min, n_min;
    logic [IW-1:0]       r_min_idx, n_min_idx;
    t_data               r_pop_val, n_pop_val;
    logic                r_min_chg, n_min_chg;
    logic                r_out_valid, n_out_valid;
    t_result             r_out, n_out;
    t_result             r_pend, n_pend;

    logic                val_we;
    logic [IW-1:0]       val_waddr;
    logic [IW-1:0]       val_raddr;
    logic [DATA_W-1:0]   val_rdata;
    logic                idx_we;
    logic [IW-1:0]       idx_raddr;
    logic [IW-1:0]       idx_rdata;

    logic                res_evt;
    t_result             res;
    logic                out_free;
    logic [CW-1:0]       count_m1;
    logic [CW-1:0]       count_m2;
    logic [CW-1:0]       min_count_m2;
    logic                nonempty;

    mts_ram #(.WIDTH(DATA_W), .DEPTH(STACK_DEPTH)) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (val_waddr),
        .i_wdata (i_in.push_value),
        .i_raddr (val_raddr),
        .o_rdata (val_rdata)
    );

    mts_ram #(.WIDTH(IW), .DEPTH(STACK_DEPTH)) u_idx_ram (
        .i_clk   (i_clk),
        .i_we    (idx_we),
        .i_waddr (r_min_count[IW-1:0]),
        .i_wdata (r_count[IW-1:0]),
        .i_raddr (idx_raddr),
        .o_rdata (idx_rdata)
    );

    assign out_free     = !r_out_valid || o_out.ready;
    assign count_m1     = r_count - CW'(1);
    assign count_m2     = r_count - CW'(2);
    assign min_count_m2 = r_min_count - CW'(2);
    assign nonempty     = (r_count != '0);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_min_count = r_min_count;
        n_top       = r_top;
        n_min       = r_min;
        n_min_idx   = r_min_idx;
        n_pop_val   = r_pop_val;
        n_min_chg   = r_min_chg;
        n_pend      = r_pend;
        val_we      = 1'b0;
        val_waddr   = r_count[IW-1:0];
        val_raddr   = count_m2[IW-1:0];
        idx_we      = 1'b0;
        idx_raddr   = min_count_m2[IW-1:0];
        res_evt     = 1'b0;
        res         = '{top_value: r_top, top_valid: nonempty, min_value: r_min,
                        min_valid: nonempty, depth: t_depth'(r_count), status: ST_DONE};
        i_in.ready  = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    res_evt = 1'b1;
                    unique case (i_in.operation)
                        OP_PUSH: begin
                            if (r_count == CW'(STACK_DEPTH)) begin
                                res.status = ST_FULL;
                            end else begin
                                val_we  = 1'b1;
                                n_top   = i_in.push_value;
                                n_count = r_count + CW'(1);
                                if (!nonempty || (i_in.push_value < r_min)) begin
                                    idx_we      = 1'b1;
                                    n_min       = i_in.push_value;
                                    n_min_idx   = r_count[IW-1:0];
                                    n_min_count = r_min_count + CW'(1);
                                end
                                res = '{top_value: i_in.push_value, top_valid: 1'b1,
                                        min_value: n_min, min_valid: 1'b1,
                                        depth: t_depth'(n_count), status: ST_DONE};
                            end
                        end
                        OP_POP: begin
                            if (!nonempty) begin
                                res = '{top_value: '0, top_valid: 1'b0, min_value: '0,
                                        min_valid: 1'b0, depth: '0, status: ST_EMPTY};
                            end else begin
                                n_count   = count_m1;
                                n_pop_val = r_top;
                                n_min_chg = (r_min_idx == count_m1[IW-1:0]);
                                if (n_min_chg) begin
                                    n_min_count = r_min_count - CW'(1);
                                end
                                if (r_count == CW'(1)) begin
                                    res = '{top_value: r_top, top_valid: 1'b1,
                                            min_value: '0, min_valid: 1'b0,
                                            depth: '0, status: ST_DONE};
                                end else begin
                                    res_evt = 1'b0;
                                    n_state = S_RD_TOP;
                                end
                            end
                        end
                        default: begin
                            if (!nonempty) begin
                                res.top_value = '0;
                                res.min_value = '0;
                            end
                        end
                    endcase
                end
            end
            S_RD_TOP: begin
                n_top = t_data'(val_rdata);
                if (r_min_chg) begin
                    n_min_idx = idx_rdata;
                    val_raddr = idx_rdata;
                    n_state   = S_RD_MIN;
                end else begin
                    res_evt = 1'b1;
                    res     = '{top_value: r_pop_val, top_valid: 1'b1, min_value: r_min,
                                min_valid: 1'b1, depth: t_depth'(r_count), status: ST_DONE};
                end
            end
            S_RD_MIN: begin
                n_min   = t_data'(val_rdata);
                res_evt = 1'b1;
                res     = '{top_value: r_pop_val, top_valid: 1'b1,
                            min_value: t_data'(val_rdata), min_valid: 1'b1,
                            depth: t_depth'(r_count), status: ST_DONE};
            end
            S_HOLD: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_out       = r_out;
        n_out_valid = r_out_valid && !o_out.ready;
        if (r_state == S_HOLD && out_free) begin
            n_out       = r_pend;
            n_out_valid = 1'b1;
        end
        if (res_evt) begin
            if (out_free) begin
                n_out       = res;
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end else begin
                n_pend  = res;
                n_state = S_HOLD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_min_count <= '0;
            r_out_valid <= 1'b0;
            r_min_chg   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_min_count <= n_min_count;
            r_out_valid <= n_out_valid;
            r_min_chg   <= n_min_chg;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top     <= n_top;
        r_min     <= n_min;
        r_min_idx <= n_min_idx;
        r_pop_val <= n_pop_val;
        r_out     <= n_out;
        r_pend    <= n_pend;
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.top_value = r_out.top_value;
    assign o_out.top_valid = r_out.top_valid;
    assign o_out.min_value = r_out.min_value;
    assign o_out.min_valid = r_out.min_valid;
    assign o_out.depth     = r_out.depth;
    assign o_out.status    = r_out.status;
endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the minimum-tracking stack with a random driver and a monitor.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mts_pkg::*;

    localparam int  CLK_PERIOD  = 20;
    localparam int  STACK_SLOTS = 256;
    localparam int  ITEM_TARGET = 1100;
    localparam int  IDLE_PCT    = 27;
    localparam int  HOLD_AT     = 400;
    localparam int  HOLD_LEN    = 300;
    localparam int  QUIET_FROM  = 1200;
    localparam int  QUIET_TO    = 1900;
    localparam int  MAX_REPORTS = 10;
    localparam int  SETTLE_CYC  = 20;

    localparam t_op OP_SPARE    = 2'd3;

    typedef struct {
        t_op   operation;
        t_data value;
        logic  drain;
    } t_stack_cmd;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mts_in_if  op_bus ();
    mts_out_if res_bus ();

    min_tracking_stack_unit #(
        .STACK_DEPTH (STACK_SLOTS)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (op_bus),
        .o_out   (res_bus)
    );

    t_stack_cmd cmd_q[$];
    t_result    expected_q[$];

    t_data      stack_vals[STACK_SLOTS];
    int         min_slots[STACK_SLOTS];
    int         n_entries;
    int         n_mins;

    int         gen_depth;
    int         items_queued;
    int         cycle_cnt;
    int         hold_left;
    int         mismatches;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Tracks the stack and its chain of minima and queues the result of one transaction.
    function automatic void predict_op(t_op op, t_data value);
        t_result r;
        logic    popped;
        int      idx;
        r = '0;
        popped = 1'b0;
        r.status = ST_DONE;
        if (op == OP_PUSH) begin
            if (n_entries >= STACK_SLOTS) begin
                r.status = ST_FULL;
            end else begin
                if (n_mins == 0 || value < stack_vals[min_slots[n_mins-1]]) begin
                    min_slots[n_mins] = n_entries;
                    n_mins++;
                end
                stack_vals[n_entries] = value;
                n_entries++;
            end
        end else if (op == OP_POP) begin
            if (n_entries == 0) begin
                r.status = ST_EMPTY;
            end else begin
                idx = n_entries - 1;
                r.top_value = stack_vals[idx];
                r.top_valid = 1'b1;
                popped = 1'b1;
                if (n_mins != 0 && min_slots[n_mins-1] == idx)
                    n_mins--;
                n_entries = idx;
            end
        end
        if (!popped && n_entries != 0) begin
            r.top_value = stack_vals[n_entries-1];
            r.top_valid = 1'b1;
        end
        if (n_entries != 0 && n_mins != 0) begin
            r.min_value = stack_vals[min_slots[n_mins-1]];
            r.min_valid = 1'b1;
        end
        r.depth = t_depth'(n_entries);
        expected_q = {expected_q, r};
    endfunction

    function automatic void queue_op(t_op op, t_data value);
        t_stack_cmd c;
        c.operation = op;
        c.value = value;
        c.drain = 1'b0;
        cmd_q = {cmd_q, c};
        items_queued++;
        if (op == OP_PUSH && gen_depth < STACK_SLOTS)
            gen_depth++;
        else if (op == OP_POP && gen_depth > 0)
            gen_depth--;
    endfunction

    function automatic void queue_drain();
        t_stack_cmd c;
        c.operation = OP_READ;
        c.value = '0;
        c.drain = 1'b1;
        cmd_q = {cmd_q, c};
    endfunction

    // Small values give many duplicate minima; the rest covers extremes and every bit.
    function automatic t_data pick_value();
        t_data v;
        case ($urandom_range(9))
            0, 1, 2, 3: v = t_data'($signed($urandom_range(6)) - 3);
            4:          v = $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
            default:    v = t_data'($urandom);
        endcase
        return v;
    endfunction

    function automatic void queue_mixed(int count);
        int sel;
        for (int k = 0; k < count; k++) begin
            sel = $urandom_range(99);
            if (sel < 45)
                queue_op(OP_PUSH, pick_value());
            else if (sel < 80)
                queue_op(OP_POP, t_data'($urandom));
            else if (sel < 92)
                queue_op(OP_READ, t_data'($urandom));
            else
                queue_op(OP_SPARE, t_data'($urandom));
        end
    endfunction

    function automatic void build_stimulus();
        t_data ramp;
        ramp = t_data'($urandom_range(5000) + 1000);
        queue_op(OP_READ, 32'sh0);
        queue_op(OP_SPARE, 32'sh12345678);
        queue_op(OP_POP, 32'sh7fffffff);
        queue_op(OP_PUSH, 32'sh7fffffff);
        queue_op(OP_PUSH, 32'sh80000000);
        queue_op(OP_PUSH, 32'sh0);
        queue_op(OP_PUSH, 32'sh80000000);
        queue_op(OP_PUSH, 32'sh5);
        queue_op(OP_READ, 32'shffffffff);
        queue_op(OP_SPARE, 32'sh0);
        queue_op(OP_POP, 32'sh0);
        queue_op(OP_POP, 32'sh0);
        queue_op(OP_POP, 32'sh0);
        queue_op(OP_POP, 32'sh0);
        queue_op(OP_POP, 32'sh0);
        queue_op(OP_POP, 32'sh0);
        queue_op(OP_PUSH, 32'shffffffff);
        queue_op(OP_PUSH, 32'shffffffff);
        queue_op(OP_POP, 32'sh0);
        queue_op(OP_READ, 32'sh0);
        queue_op(OP_POP, 32'sh0);
        queue_drain();

        queue_mixed(250);
        queue_drain();

        while (gen_depth < STACK_SLOTS) begin
            if ($urandom_range(1)) begin
                queue_op(OP_PUSH, ramp);
                ramp = ramp - t_data'($urandom_range(2));
            end else begin
                queue_op(OP_PUSH, pick_value());
            end
        end
        for (int k = 0; k < 4; k++)
            queue_op(OP_PUSH, pick_value());
        queue_op(OP_READ, 32'sh0);
        queue_op(OP_SPARE, 32'sh0);
        queue_drain();

        while (gen_depth > 0)
            queue_op($urandom_range(9) == 0 ? OP_READ : OP_POP, t_data'($urandom));
        for (int k = 0; k < 3; k++)
            queue_op(OP_POP, t_data'($urandom));
        queue_drain();

        while (items_queued < ITEM_TARGET)
            queue_mixed(20);
    endfunction

    initial begin
        op_bus.valid = 1'b0;
        op_bus.operation = OP_READ;
        op_bus.push_value = '0;
        res_bus.ready = 1'b0;
        n_entries = 0;
        n_mins = 0;
        gen_depth = 0;
        items_queued = 0;
        mismatches = 0;
        build_stimulus();
    end

    // Driver: holds an offered transaction until it is taken and pauses at drain markers.
    always @(posedge i_clk) begin
        logic offer;
        logic quiet;
        offer = 1'b0;
        quiet = (cycle_cnt >= QUIET_FROM && cycle_cnt < QUIET_TO);
        if (!i_rst_n) begin
            op_bus.valid <= 1'b0;
        end else begin
            if (op_bus.valid && op_bus.ready) begin
                predict_op(op_bus.operation, op_bus.push_value);
                void'(cmd_q.pop_front());
            end
            if (cmd_q.size() > 0 && cmd_q[0].drain && expected_q.size() == 0)
                void'(cmd_q.pop_front());
            if (op_bus.valid && !op_bus.ready)
                offer = 1'b1;
            else if (cmd_q.size() > 0 && !cmd_q[0].drain)
                offer = quiet || ($urandom_range(99) >= IDLE_PCT);
            op_bus.valid <= offer;
            if (offer) begin
                op_bus.operation <= cmd_q[0].operation;
                op_bus.push_value <= cmd_q[0].value;
            end
        end
    end

    // Receiver: random back-pressure plus one long hold-off to fill the block.
    always @(posedge i_clk) begin
        logic quiet;
        quiet = (cycle_cnt >= QUIET_FROM && cycle_cnt < QUIET_TO);
        if (!i_rst_n) begin
            res_bus.ready <= 1'b0;
            cycle_cnt <= 0;
            hold_left <= 0;
        end else begin
            cycle_cnt <= cycle_cnt + 1;
            if (cycle_cnt == HOLD_AT)
                hold_left <= HOLD_LEN;
            else if (hold_left != 0)
                hold_left <= hold_left - 1;
            res_bus.ready <= (hold_left == 0) && (cycle_cnt != HOLD_AT)
                             && (quiet || $urandom_range(99) >= IDLE_PCT);
        end
    end

    // Monitor: compares every result transaction with the oldest prediction.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            got.top_value = res_bus.top_value;
            got.top_valid = res_bus.top_valid;
            got.min_value = res_bus.min_value;
            got.min_valid = res_bus.min_valid;
            got.depth     = res_bus.depth;
            got.status    = res_bus.status;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("Unexpected result: top=%0d/%0b min=%0d/%0b depth=%0d st=%0d",
                             got.top_value, got.top_valid, got.min_value, got.min_valid,
                             got.depth, got.status);
            end else begin
                want = expected_q.pop_front();
                if (got.top_value !== want.top_value || got.top_valid !== want.top_valid
                        || got.min_value !== want.min_value
                        || got.min_valid !== want.min_valid
                        || got.depth !== want.depth || got.status !== want.status) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("Mismatch at %0t: expected top=%0d/%0b min=%0d/%0b d=%0d st=%0d",
                                 $realtime, want.top_value, want.top_valid, want.min_value,
                                 want.min_valid, want.depth, want.status);
                        $display("  actual   top=%0d/%0b min=%0d/%0b d=%0d st=%0d",
                                 got.top_value, got.top_valid, got.min_value, got.min_valid,
                                 got.depth, got.status);
                    end
                end
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (cmd_q.size() != 0 || expected_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #5ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/mts_pkg.sv
rtl/mts_in_if.sv
rtl/mts_out_if.sv
rtl/mts_ram.sv
rtl/min_tracking_stack_unit.sv
tb/testbench.sv
